FILE: design/hbr_pkg.sv
// ----------------------------------------------------------------------------
// hbr_pkg
// Shared types, request codes and constants for the HID boot request and
// idle reporter.
// ----------------------------------------------------------------------------
package hbr_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SETUP = 2'd1;
  localparam logic [1:0] ACT_LED   = 2'd2;
  localparam logic [1:0] ACT_READY = 2'd3;

  localparam logic [7:0] RQ_GET_REPORT   = 8'd1;
  localparam logic [7:0] RQ_GET_IDLE     = 8'd2;
  localparam logic [7:0] RQ_GET_PROTOCOL = 8'd3;
  localparam logic [7:0] RQ_SET_REPORT   = 8'd9;
  localparam logic [7:0] RQ_SET_IDLE     = 8'd10;
  localparam logic [7:0] RQ_SET_PROTOCOL = 8'd11;

  localparam logic [1:0] REQ_TYPE_CLASS = 2'b01;

  localparam logic       CFG_MOUSE_IF    = 1'b0;
  localparam logic       CFG_MOUSE_BYTES = 1'b1;

  localparam logic [7:0] MOUSE_IF_RESET    = 8'd1;
  localparam logic [2:0] MOUSE_BYTES_RESET = 3'd3;
  localparam logic [3:0] KBD_REPORT_LEN    = 4'd8;
  localparam logic [7:0] KBD_IDLE_DEFAULT  = 8'd125;
  localparam logic [7:0] MOUSE_IDLE_DEFAULT = 8'd0;
  localparam logic [7:0] PROTOCOL_DEFAULT  = 8'd1;
  localparam logic [7:0] LEDS_DEFAULT      = 8'hff;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_GET_REPORT,
    OP_SET_REPORT,
    OP_GET_IDLE,
    OP_SET_IDLE,
    OP_GET_PROTOCOL,
    OP_SET_PROTOCOL,
    OP_LED,
    OP_MARK
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       is_mouse;
    logic [7:0] arg;
    logic       flag;
    logic       kbd_rdy;
    logic       mouse_rdy;
  } cmd_t;

  typedef struct packed {
    logic [3:0] reply_len;
    logic [7:0] reply_byte;
    logic       expect_out_data;
    logic       send_kbd;
    logic       send_mouse;
    logic [7:0] led_state;
    logic       led_changed;
  } res_t;

endpackage

FILE: design/hbr_front.sv
// ----------------------------------------------------------------------------
// hbr_front
// Classifies an incoming item into a compact command for the back end.
// ----------------------------------------------------------------------------
module hbr_front import hbr_pkg::*; (
  input  logic [1:0]  action_i,
  input  logic [7:0]  elapsed_units_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] value_word_i,
  input  logic [15:0] index_word_i,
  input  logic [15:0] length_word_i,
  input  logic [7:0]  led_byte_i,
  input  logic        report_for_mouse_i,
  input  logic        keyboard_ep_ready_i,
  input  logic        mouse_ep_ready_i,
  input  logic [7:0]  mouse_if_i,
  output cmd_t        cmd_o
);

  logic is_mouse;
  logic is_class;

  assign is_mouse = (index_word_i == {8'd0, mouse_if_i});
  assign is_class = (request_type_i[6:5] == REQ_TYPE_CLASS);

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.kbd_rdy   = keyboard_ep_ready_i;
    cmd_o.mouse_rdy = mouse_ep_ready_i;
    case (action_i)
      ACT_TICK: begin
        cmd_o.op  = OP_TICK;
        cmd_o.arg = elapsed_units_i;
      end
      ACT_SETUP: begin
        cmd_o.is_mouse = is_mouse;
        if (is_class) begin
          case (request_code_i)
            RQ_GET_REPORT:   cmd_o.op = OP_GET_REPORT;
            RQ_GET_IDLE:     cmd_o.op = OP_GET_IDLE;
            RQ_GET_PROTOCOL: cmd_o.op = OP_GET_PROTOCOL;
            RQ_SET_REPORT: begin
              cmd_o.op   = OP_SET_REPORT;
              cmd_o.flag = !is_mouse && (length_word_i == 16'd1);
            end
            RQ_SET_IDLE: begin
              cmd_o.op  = OP_SET_IDLE;
              cmd_o.arg = value_word_i[15:8];
            end
            RQ_SET_PROTOCOL: begin
              cmd_o.op  = OP_SET_PROTOCOL;
              cmd_o.arg = value_word_i[7:0];
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      ACT_LED: begin
        cmd_o.op  = OP_LED;
        cmd_o.arg = led_byte_i;
      end
      ACT_READY: begin
        cmd_o.op       = OP_MARK;
        cmd_o.is_mouse = report_for_mouse_i;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: design/hbr_queue.sv
// ----------------------------------------------------------------------------
// hbr_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module hbr_queue import hbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: design/hbr_back.sv
// ----------------------------------------------------------------------------
// hbr_back
// Executes commands against the interface state and registers one result.
// ----------------------------------------------------------------------------
module hbr_back import hbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  input  logic [2:0] mouse_bytes_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  logic [7:0] kbd_rate_q, kbd_rate_d;
  logic [7:0] mouse_rate_q, mouse_rate_d;
  logic [7:0] kbd_proto_q, kbd_proto_d;
  logic [7:0] mouse_proto_q, mouse_proto_d;
  logic [7:0] kbd_time_q, kbd_time_d;
  logic [7:0] mouse_time_q, mouse_time_d;
  logic       kbd_dirty_q, kbd_dirty_d;
  logic       mouse_dirty_q, mouse_dirty_d;
  logic [7:0] leds_q, leds_d;
  logic       res_valid_q;
  res_t       res_q, res_d;
  logic       take;
  logic [7:0] kbd_sum, mouse_sum;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign kbd_sum     = kbd_time_q + cmd_i.arg;
  assign mouse_sum   = mouse_time_q + cmd_i.arg;

  always_comb begin
    kbd_rate_d    = kbd_rate_q;
    mouse_rate_d  = mouse_rate_q;
    kbd_proto_d   = kbd_proto_q;
    mouse_proto_d = mouse_proto_q;
    kbd_time_d    = kbd_time_q;
    mouse_time_d  = mouse_time_q;
    kbd_dirty_d   = kbd_dirty_q;
    mouse_dirty_d = mouse_dirty_q;
    leds_d        = leds_q;
    res_d         = '0;
    case (cmd_i.op)
      OP_TICK: begin
        if (kbd_rate_q != 8'd0) begin
          kbd_time_d = kbd_sum;
          if (kbd_sum >= kbd_rate_q) begin
            kbd_time_d  = 8'd0;
            kbd_dirty_d = 1'b1;
          end
        end
        if (mouse_rate_q != 8'd0) begin
          mouse_time_d = mouse_sum;
          if (mouse_sum >= mouse_rate_q) begin
            mouse_time_d  = 8'd0;
            mouse_dirty_d = 1'b1;
          end
        end
        if (kbd_dirty_d && cmd_i.kbd_rdy) begin
          res_d.send_kbd = 1'b1;
          kbd_dirty_d    = 1'b0;
        end
        if (mouse_dirty_d && cmd_i.mouse_rdy) begin
          res_d.send_mouse = 1'b1;
          mouse_dirty_d    = 1'b0;
        end
      end
      OP_GET_REPORT: begin
        res_d.reply_len = cmd_i.is_mouse ? {1'b0, mouse_bytes_i} : KBD_REPORT_LEN;
      end
      OP_SET_REPORT: res_d.expect_out_data = cmd_i.flag;
      OP_GET_IDLE: begin
        res_d.reply_len  = 4'd1;
        res_d.reply_byte = cmd_i.is_mouse ? mouse_rate_q : kbd_rate_q;
      end
      OP_SET_IDLE: begin
        if (cmd_i.is_mouse) begin
          mouse_rate_d = cmd_i.arg;
        end else begin
          kbd_rate_d = cmd_i.arg;
        end
      end
      OP_GET_PROTOCOL: begin
        res_d.reply_len  = 4'd1;
        res_d.reply_byte = cmd_i.is_mouse ? mouse_proto_q : kbd_proto_q;
      end
      OP_SET_PROTOCOL: begin
        if (cmd_i.is_mouse) begin
          mouse_proto_d = cmd_i.arg;
        end else begin
          kbd_proto_d = cmd_i.arg;
        end
      end
      OP_LED: begin
        if (cmd_i.arg != leds_q) begin
          leds_d            = cmd_i.arg;
          res_d.led_changed = 1'b1;
        end
      end
      OP_MARK: begin
        if (cmd_i.is_mouse) begin
          mouse_dirty_d = 1'b1;
        end else begin
          kbd_dirty_d = 1'b1;
        end
      end
      default: ;
    endcase
    res_d.led_state = leds_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_rate_q    <= KBD_IDLE_DEFAULT;
      mouse_rate_q  <= MOUSE_IDLE_DEFAULT;
      kbd_proto_q   <= PROTOCOL_DEFAULT;
      mouse_proto_q <= PROTOCOL_DEFAULT;
      kbd_time_q    <= 8'd0;
      mouse_time_q  <= 8'd0;
      kbd_dirty_q   <= 1'b0;
      mouse_dirty_q <= 1'b0;
      leds_q        <= LEDS_DEFAULT;
      res_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        kbd_rate_q    <= kbd_rate_d;
        mouse_rate_q  <= mouse_rate_d;
        kbd_proto_q   <= kbd_proto_d;
        mouse_proto_q <= mouse_proto_d;
        kbd_time_q    <= kbd_time_d;
        mouse_time_q  <= mouse_time_d;
        kbd_dirty_q   <= kbd_dirty_d;
        mouse_dirty_q <= mouse_dirty_d;
        leds_q        <= leds_d;
        res_valid_q   <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: design/hid_boot_request_and_idle_reporter.sv
// ----------------------------------------------------------------------------
// hid_boot_request_and_idle_reporter
// An input enters the queue; the back end then registers its result.
// Throughput: one item per cycle while out_ready_i takes each result.
// The 2-entry command queue and the result register decouple both sides.
// Reset clears all interface state to its defaults; no clearing pass.
// ----------------------------------------------------------------------------
module hid_boot_request_and_idle_reporter import hbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  elapsed_units_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] value_word_i,
  input  logic [15:0] index_word_i,
  input  logic [15:0] length_word_i,
  input  logic [7:0]  led_byte_i,
  input  logic        report_for_mouse_i,
  input  logic        keyboard_ep_ready_i,
  input  logic        mouse_ep_ready_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  reply_len_o,
  output logic [7:0]  reply_byte_o,
  output logic        expect_out_data_o,
  output logic        send_keyboard_report_o,
  output logic        send_mouse_report_o,
  output logic [7:0]  led_state_o,
  output logic        led_changed_o
);

  logic [7:0] mouse_if_q;
  logic [2:0] mouse_bytes_q;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       head_valid;
  logic       head_ready;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mouse_if_q    <= MOUSE_IF_RESET;
      mouse_bytes_q <= MOUSE_BYTES_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MOUSE_IF) begin
        mouse_if_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_MOUSE_BYTES) begin
        mouse_bytes_q <= cfg_data_i[2:0];
      end
    end
  end

  hbr_front u_front (
    .action_i            (action_i),
    .elapsed_units_i     (elapsed_units_i),
    .request_type_i      (request_type_i),
    .request_code_i      (request_code_i),
    .value_word_i        (value_word_i),
    .index_word_i        (index_word_i),
    .length_word_i       (length_word_i),
    .led_byte_i          (led_byte_i),
    .report_for_mouse_i  (report_for_mouse_i),
    .keyboard_ep_ready_i (keyboard_ep_ready_i),
    .mouse_ep_ready_i    (mouse_ep_ready_i),
    .mouse_if_i          (mouse_if_q),
    .cmd_o               (front_cmd)
  );

  hbr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_cmd_o    (head_cmd)
  );

  hbr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_ready_o   (head_ready),
    .cmd_i         (head_cmd),
    .mouse_bytes_i (mouse_bytes_q),
    .res_valid_o   (out_valid_o),
    .res_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign reply_len_o            = res.reply_len;
  assign reply_byte_o           = res.reply_byte;
  assign expect_out_data_o      = res.expect_out_data;
  assign send_keyboard_report_o = res.send_kbd;
  assign send_mouse_report_o    = res.send_mouse;
  assign led_state_o            = res.led_state;
  assign led_changed_o          = res.led_changed;

endmodule
